/* src/pfa_pkg.sv */
package pfa_pkg;

    localparam int DEF_CAPACITY  = 64;
    localparam int DEF_OBJ_WIDTH = 32;
    localparam int FIELD_W       = 32;
    localparam int IN_IDX_W      = 6;
    localparam int SIZE_W        = 7;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_READ   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

    // Control broadcast from the sequencer to every cell of the chain
    typedef struct packed {
        logic shift;
        logic wr_en;
    } t_cell_ctl;

endpackage

/* src/pareto_front_archive.sv */
// Channel   | Handshake                  | Payload
// ----------+----------------------------+-------------------------------------------
// input     | i_in_valid / o_in_ready    | i_mode, i_obj_a/b/c, i_entry_index
// result    | o_out_valid / i_out_ready  | o_accepted .. o_read_c
// config    | i_cfg_wr_en                | i_cfg_wr_data (maximize)
//
// Clear skips the scan; insert, query and read stream the front, as it stands when
// the transaction is accepted, once through the single dominance comparator at the
// head of the cell chain, one entry a cycle.
// Reset (synchronous, active low) empties the front and clears maximize.
// A new transaction is taken while a result waits; the next result holds until
// the waiting one has been taken.
module pareto_front_archive
    import pfa_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int OBJ_WIDTH = DEF_OBJ_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_mode,
    input  logic [FIELD_W-1:0]  i_obj_a,
    input  logic [FIELD_W-1:0]  i_obj_b,
    input  logic [FIELD_W-1:0]  i_obj_c,
    input  logic [IN_IDX_W-1:0] i_entry_index,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_accepted,
    output logic                o_improves,
    output logic [SIZE_W-1:0]   o_removed_count,
    output logic [SIZE_W-1:0]   o_front_size,
    output logic                o_overflow,
    output logic                o_read_valid,
    output logic [FIELD_W-1:0]  o_read_a,
    output logic [FIELD_W-1:0]  o_read_b,
    output logic [FIELD_W-1:0]  o_read_c
);

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int ENTRY_W = 3 * OBJ_WIDTH;

    t_cell_ctl          w_ctl;
    logic [IDX_W-1:0]   w_wr_idx;
    logic [ENTRY_W-1:0] w_wr_data;
    logic [ENTRY_W-1:0] w_cell [CAPACITY];

    pfa_ctrl #(
        .CAPACITY  (CAPACITY),
        .OBJ_WIDTH (OBJ_WIDTH)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_obj_a         (i_obj_a),
        .i_obj_b         (i_obj_b),
        .i_obj_c         (i_obj_c),
        .i_entry_index   (i_entry_index),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_accepted      (o_accepted),
        .o_improves      (o_improves),
        .o_removed_count (o_removed_count),
        .o_front_size    (o_front_size),
        .o_overflow      (o_overflow),
        .o_read_valid    (o_read_valid),
        .o_read_a        (o_read_a),
        .o_read_b        (o_read_b),
        .o_read_c        (o_read_c),
        .i_head          (w_cell[0]),
        .o_cell_ctl      (w_ctl),
        .o_wr_idx        (w_wr_idx),
        .o_wr_data       (w_wr_data)
    );

    // cell 0 is the head; each cell takes its right neighbour on a shift
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ENTRY_W-1:0] w_right;
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid
            assign w_right = w_cell[g+1];
        end
        pfa_cell #(
            .CAPACITY  (CAPACITY),
            .OBJ_WIDTH (OBJ_WIDTH),
            .INDEX     (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_wr_idx  (w_wr_idx),
            .i_wr_data (w_wr_data),
            .i_right   (w_right),
            .o_data    (w_cell[g])
        );
    end

endmodule

/* src/pfa_cell.sv */
module pfa_cell
    import pfa_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int OBJ_WIDTH = DEF_OBJ_WIDTH,
    parameter int INDEX     = 0,
    localparam int IDX_W    = $clog2(CAPACITY),
    localparam int ENTRY_W  = 3 * OBJ_WIDTH
) (
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic [IDX_W-1:0]   i_wr_idx,
    input  logic [ENTRY_W-1:0] i_wr_data,
    input  logic [ENTRY_W-1:0] i_right,
    output logic [ENTRY_W-1:0] o_data
);

    logic [ENTRY_W-1:0] r_data;
    logic               w_hit;

    assign w_hit  = i_ctl.wr_en && (i_wr_idx == IDX_W'(INDEX));
    assign o_data = r_data;

    // A tail write takes priority over the shift towards the head
    always_ff @(posedge i_clk) begin
        if (w_hit) begin
            r_data <= i_wr_data;
        end else if (i_ctl.shift) begin
            r_data <= i_right;
        end
    end

endmodule

/* src/pfa_ctrl.sv */
module pfa_ctrl
    import pfa_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int OBJ_WIDTH = DEF_OBJ_WIDTH,
    localparam int IDX_W    = $clog2(CAPACITY),
    localparam int CNT_W    = $clog2(CAPACITY + 1),
    localparam int ENTRY_W  = 3 * OBJ_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_mode,
    input  logic [FIELD_W-1:0]  i_obj_a,
    input  logic [FIELD_W-1:0]  i_obj_b,
    input  logic [FIELD_W-1:0]  i_obj_c,
    input  logic [IN_IDX_W-1:0] i_entry_index,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_accepted,
    output logic                o_improves,
    output logic [SIZE_W-1:0]   o_removed_count,
    output logic [SIZE_W-1:0]   o_front_size,
    output logic                o_overflow,
    output logic                o_read_valid,
    output logic [FIELD_W-1:0]  o_read_a,
    output logic [FIELD_W-1:0]  o_read_b,
    output logic [FIELD_W-1:0]  o_read_c,
    input  logic [ENTRY_W-1:0]  i_head,
    output t_cell_ctl           o_cell_ctl,
    output logic [IDX_W-1:0]    o_wr_idx,
    output logic [ENTRY_W-1:0]  o_wr_data
);

    localparam int CMP_W = (IDX_W > IN_IDX_W) ? IDX_W : IN_IDX_W;

    // control
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_len, n_len;
    logic                r_out_valid, n_out_valid;
    logic                r_maximize;

    // working payload
    t_mode               r_mode, n_mode;
    logic [ENTRY_W-1:0]  r_cand, n_cand;
    logic [IN_IDX_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0]    r_left, n_left;
    logic [IDX_W-1:0]    r_pos, n_pos;
    logic                r_blocked, n_blocked;
    logic [CNT_W-1:0]    r_removed, n_removed;
    logic                r_rd_hit, n_rd_hit;
    logic [ENTRY_W-1:0]  r_rd, n_rd;

    // result register
    logic                r_o_acc, n_o_acc;
    logic                r_o_imp, n_o_imp;
    logic [SIZE_W-1:0]   r_o_rem, n_o_rem;
    logic [SIZE_W-1:0]   r_o_size, n_o_size;
    logic                r_o_ovf, n_o_ovf;
    logic                r_o_rdv, n_o_rdv;
    logic [FIELD_W-1:0]  r_o_ra, n_o_ra;
    logic [FIELD_W-1:0]  r_o_rb, n_o_rb;
    logic [FIELD_W-1:0]  r_o_rc, n_o_rc;

    // dominance of candidate against the head cell
    logic [2:0]          w_cand_better;
    logic [2:0]          w_head_better;
    logic                w_cand_dom;
    logic                w_head_covers;
    logic                w_keep;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_maximize) begin
                w_cand_better[k] = r_cand[k*OBJ_WIDTH +: OBJ_WIDTH]
                                 > i_head[k*OBJ_WIDTH +: OBJ_WIDTH];
                w_head_better[k] = i_head[k*OBJ_WIDTH +: OBJ_WIDTH]
                                 > r_cand[k*OBJ_WIDTH +: OBJ_WIDTH];
            end else begin
                w_cand_better[k] = r_cand[k*OBJ_WIDTH +: OBJ_WIDTH]
                                 < i_head[k*OBJ_WIDTH +: OBJ_WIDTH];
                w_head_better[k] = i_head[k*OBJ_WIDTH +: OBJ_WIDTH]
                                 < r_cand[k*OBJ_WIDTH +: OBJ_WIDTH];
            end
        end
    end

    assign w_cand_dom    = (|w_cand_better) && !(|w_head_better);
    assign w_head_covers = !(|w_cand_better);   // dominates or equals
    // Front is mutually non-dominated, so a dominated head implies no blocker
    assign w_keep        = !((r_mode == MODE_INSERT) && w_cand_dom);

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_out_valid = r_out_valid;
        n_mode      = r_mode;
        n_cand      = r_cand;
        n_idx       = r_idx;
        n_left      = r_left;
        n_pos       = r_pos;
        n_blocked   = r_blocked;
        n_removed   = r_removed;
        n_rd_hit    = r_rd_hit;
        n_rd        = r_rd;
        n_o_acc     = r_o_acc;
        n_o_imp     = r_o_imp;
        n_o_rem     = r_o_rem;
        n_o_size    = r_o_size;
        n_o_ovf     = r_o_ovf;
        n_o_rdv     = r_o_rdv;
        n_o_ra      = r_o_ra;
        n_o_rb      = r_o_rb;
        n_o_rc      = r_o_rc;
        o_in_ready  = 1'b0;
        o_cell_ctl  = '0;
        o_wr_idx    = '0;
        o_wr_data   = r_cand;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_mode    = t_mode'(i_mode);
                    n_cand    = {i_obj_c[OBJ_WIDTH-1:0], i_obj_b[OBJ_WIDTH-1:0],
                                 i_obj_a[OBJ_WIDTH-1:0]};
                    n_idx     = i_entry_index;
                    n_left    = r_len;
                    n_pos     = '0;
                    n_blocked = 1'b0;
                    n_removed = '0;
                    n_rd_hit  = 1'b0;
                    n_rd      = '0;
                    if ((t_mode'(i_mode) == MODE_CLEAR) || (r_len == '0)) begin
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // pop the head, push it back at the tail unless it is removed
                o_cell_ctl.shift = 1'b1;
                o_cell_ctl.wr_en = w_keep;
                o_wr_idx         = IDX_W'(r_len - CNT_W'(1));
                o_wr_data        = i_head;
                if (!w_keep) begin
                    n_len     = r_len - CNT_W'(1);
                    n_removed = r_removed + CNT_W'(1);
                end
                if (w_head_covers) begin
                    n_blocked = 1'b1;
                end
                if ((r_mode == MODE_READ) && (CMP_W'(r_pos) == CMP_W'(r_idx))) begin
                    n_rd_hit = 1'b1;
                    n_rd     = i_head;
                end
                n_pos  = r_pos + IDX_W'(1);
                n_left = r_left - CNT_W'(1);
                if (r_left == CNT_W'(1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                    n_o_acc     = 1'b0;
                    n_o_ovf     = 1'b0;
                    n_o_imp     = 1'b0;
                    n_o_rem     = '0;
                    n_o_rdv     = r_rd_hit;
                    n_o_ra      = FIELD_W'(r_rd[0*OBJ_WIDTH +: OBJ_WIDTH]);
                    n_o_rb      = FIELD_W'(r_rd[1*OBJ_WIDTH +: OBJ_WIDTH]);
                    n_o_rc      = FIELD_W'(r_rd[2*OBJ_WIDTH +: OBJ_WIDTH]);
                    priority case (r_mode)
                        MODE_CLEAR: begin
                            n_len = '0;
                        end
                        MODE_INSERT: begin
                            n_o_imp = !r_blocked;
                            n_o_rem = SIZE_W'(r_removed);
                            if (!r_blocked) begin
                                if (r_len < CNT_W'(CAPACITY)) begin
                                    o_cell_ctl.wr_en = 1'b1;
                                    o_wr_idx         = IDX_W'(r_len);
                                    n_len            = r_len + CNT_W'(1);
                                    n_o_acc          = 1'b1;
                                end else begin
                                    n_o_ovf = 1'b1;
                                end
                            end
                        end
                        MODE_QUERY: begin
                            n_o_imp = !r_blocked;
                        end
                        default: begin
                        end
                    endcase
                    n_o_size = SIZE_W'(n_len);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
            r_maximize  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_maximize <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_cand    <= n_cand;
        r_idx     <= n_idx;
        r_left    <= n_left;
        r_pos     <= n_pos;
        r_blocked <= n_blocked;
        r_removed <= n_removed;
        r_rd_hit  <= n_rd_hit;
        r_rd      <= n_rd;
        r_o_acc   <= n_o_acc;
        r_o_imp   <= n_o_imp;
        r_o_rem   <= n_o_rem;
        r_o_size  <= n_o_size;
        r_o_ovf   <= n_o_ovf;
        r_o_rdv   <= n_o_rdv;
        r_o_ra    <= n_o_ra;
        r_o_rb    <= n_o_rb;
        r_o_rc    <= n_o_rc;
    end

    assign o_out_valid     = r_out_valid;
    assign o_accepted      = r_o_acc;
    assign o_improves      = r_o_imp;
    assign o_removed_count = r_o_rem;
    assign o_front_size    = r_o_size;
    assign o_overflow      = r_o_ovf;
    assign o_read_valid    = r_o_rdv;
    assign o_read_a        = r_o_ra;
    assign o_read_b        = r_o_rb;
    assign o_read_c        = r_o_rc;

endmodule

/* src/pfa_checker.sv */
module pfa_checker
    import pfa_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic                o_accepted,
    input logic                o_improves,
    input logic [SIZE_W-1:0]   o_front_size,
    input logic                o_overflow,
    input logic                o_read_valid,
    input logic [FIELD_W-1:0]  o_read_a,
    input logic [FIELD_W-1:0]  o_read_b,
    input logic [FIELD_W-1:0]  o_read_c
);

    // a stalled result stays valid and keeps its front size and accepted flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_front_size)
            && $stable(o_accepted))
        else $error("result changed while stalled");

    a_acc_imp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_accepted || o_overflow) |-> o_improves)
        else $error("accepted or overflow without improvement");

    a_acc_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_accepted && o_overflow))
        else $error("accepted and overflow together");

    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_read_valid |-> (o_read_a == '0) && (o_read_b == '0)
            && (o_read_c == '0))
        else $error("read fields not zero on invalid read");

endmodule

bind pareto_front_archive pfa_checker u_pfa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_accepted   (o_accepted),
    .o_improves   (o_improves),
    .o_front_size (o_front_size),
    .o_overflow   (o_overflow),
    .o_read_valid (o_read_valid),
    .o_read_a     (o_read_a),
    .o_read_b     (o_read_b),
    .o_read_c     (o_read_c)
);
